/* hdl/matrix_vector_multiply_accumulate_core_assert.svh */
// Assertion macros for the matrix-vector multiply-accumulate core
`ifndef MATRIX_VECTOR_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MVMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MVMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MVMA_ASSERT_IMP(lbl, ante, cons, msg)
`define MVMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/mvma_pkg.sv */
// Shared types and constants of the matrix-vector multiply-accumulate core
package mvma_pkg;

  localparam int VAL_W = 16;
  localparam int C_W   = 32;
  localparam int SUM_W = 48;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_TRANSP = 2'd3;

  localparam logic signed [39:0] RES_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] RES_MIN = 40'shFF_8000_0000;

  typedef struct packed {
    logic                    go;
    logic [SUM_W-1:0]        sum;
    logic signed [C_W-1:0]   cin;
    logic signed [VAL_W-1:0] scale;
  } fin_req_t;

  typedef struct packed {
    logic                  valid;
    logic signed [C_W-1:0] value;
    logic                  sat;
  } fin_res_t;

endpackage

/* hdl/mvma_ram.sv */
// Simple dual-port synchronous RAM, registered read
module mvma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mvma_finish.sv */
// Scale, shift, add and saturate unit for a finished output word
module mvma_finish
  import mvma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fin_req_t req,
  output fin_res_t res
);

  logic [3:0]              ph_r;
  logic [SUM_W-1:0]        sum_r;
  logic signed [C_W-1:0]   cin_r;
  logic signed [VAL_W-1:0] scale_r;
  logic signed [40:0]      p_lo_r;
  logic signed [40:0]      p_hi_r;
  logic signed [63:0]      full_r;
  logic                    valid_r;
  logic signed [C_W-1:0]   value_r;
  logic                    sat_r;

  logic signed [24:0] op;
  logic signed [40:0] mul;
  logic signed [63:0] full_nxt;
  logic signed [39:0] r_nxt;

  // one shared 16x25 multiplier, low half then high half of the sum
  assign op       = ph_r[1] ? $signed({sum_r[47], sum_r[47:24]}) : $signed({1'b0, sum_r[23:0]});
  assign mul      = scale_r * op;
  assign full_nxt = (64'(p_hi_r) <<< 24) + 64'(p_lo_r);
  assign r_nxt    = 40'(cin_r) + 40'($signed(full_r[63:26]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      ph_r    <= {ph_r[2:0], req.go};
      valid_r <= ph_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      sum_r   <= req.sum;
      cin_r   <= req.cin;
      scale_r <= req.scale;
    end
    if (ph_r[0]) begin
      p_lo_r <= mul;
    end
    if (ph_r[1]) begin
      p_hi_r <= mul;
    end
    if (ph_r[2]) begin
      full_r <= full_nxt;
    end
    if (ph_r[3]) begin
      if (r_nxt > RES_MAX) begin
        value_r <= C_W'(RES_MAX);
        sat_r   <= 1'b1;
      end else if (r_nxt < RES_MIN) begin
        value_r <= C_W'(RES_MIN);
        sat_r   <= 1'b1;
      end else begin
        value_r <= C_W'(r_nxt);
        sat_r   <= 1'b0;
      end
    end
  end

  assign res.valid = valid_r;
  assign res.value = value_r;
  assign res.sat   = sat_r;

endmodule

/* hdl/matrix_vector_multiply_accumulate_core.sv */
// Matrix-vector multiply-accumulate core: c[i] += d * sum_p A[i][p] * b[p]
// Vector words are written into the vector RAM on acceptance; busy stays low.
// Matrix words: read, multiply, accumulate; busy stays high until the core is back in idle.
// Finishing words: the core waits in S_FIN for the four-step scale unit, with its
// shared 16x25 multiplier, to raise out_strobe, then returns to idle for the next word.
// Reset clears state, positions, running sum and configuration registers; both RAMs need no clearing.
`include "matrix_vector_multiply_accumulate_core_assert.svh"
module matrix_vector_multiply_accumulate_core
  import mvma_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [C_W-1:0]   in_c_in,
  output logic                    out_strobe,
  output logic signed [C_W-1:0]   out_c_out,
  output logic [7:0]              out_row_index,
  output logic                    out_saturated,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int RA = $clog2(MAX_ROWS);
  localparam int CA = $clog2(MAX_COLS);
  localparam int PA = (RA > CA) ? RA : CA;
  localparam int RS = $clog2(MAX_ROWS + 1);
  localparam int CS = $clog2(MAX_COLS + 1);
  localparam int LW = (RS > CS) ? RS : CS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [8:0]              rows_cfg_r;
  logic [8:0]              cols_cfg_r;
  logic signed [VAL_W-1:0] scale_r;
  logic                    transp_r;
  logic [PA-1:0]           outer_r, outer_nxt;
  logic [PA-1:0]           inner_r, inner_nxt;
  logic [CA-1:0]           load_r;
  logic [SUM_W-1:0]        running_sum_r;
  logic signed [VAL_W-1:0] a_r;
  logic signed [C_W-1:0]   cin_r;
  logic                    fin_r;
  logic                    first_r;
  logic [7:0]              idx_r;
  logic [RA-1:0]           sum_addr_r;
  logic signed [31:0]      prod_r;

  logic [RS-1:0]           rows_eff;
  logic [CS-1:0]           cols_eff;
  logic [LW-1:0]           outer_lim, inner_lim;
  logic                    outer_last, inner_last;
  logic                    accept, acc_mat, acc_vec;
  logic [SUM_W-1:0]        prev_sum, acc_sum;
  logic signed [VAL_W-1:0] vec_rdata;
  logic [SUM_W-1:0]        sum_rdata;
  logic [CA-1:0]           vec_raddr;
  fin_req_t                fin_req;
  fin_res_t                fin_res;

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = RS'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = RS'(MAX_ROWS);
    end else begin
      rows_eff = RS'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CS'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = CS'(MAX_COLS);
    end else begin
      cols_eff = CS'(cols_cfg_r);
    end
  end

  assign outer_lim  = transp_r ? LW'(cols_eff) : LW'(rows_eff);
  assign inner_lim  = transp_r ? LW'(rows_eff) : LW'(cols_eff);
  assign outer_last = (32'(outer_r) + 32'd1) >= 32'(outer_lim);
  assign inner_last = (32'(inner_r) + 32'd1) >= 32'(inner_lim);
  assign inner_nxt  = inner_last ? '0 : inner_r + PA'(1);
  assign outer_nxt  = inner_last ? (outer_last ? '0 : outer_r + PA'(1)) : outer_r;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign acc_mat = accept && in_kind;
  assign acc_vec = accept && !in_kind;

  assign vec_raddr = transp_r ? outer_r[CA-1:0] : inner_r[CA-1:0];

  mvma_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (acc_vec),
    .waddr (load_r),
    .wdata (in_value),
    .re    (acc_mat),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  mvma_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_sum_ram (
    .clk   (clk),
    .we    ((state_r == S_ACC) && transp_r),
    .waddr (sum_addr_r),
    .wdata (acc_sum),
    .re    (acc_mat),
    .raddr (inner_r[RA-1:0]),
    .rdata (sum_rdata)
  );

  assign prev_sum = transp_r ? (first_r ? '0 : sum_rdata) : running_sum_r;
  assign acc_sum  = prev_sum + SUM_W'(prod_r);

  assign fin_req.go    = (state_r == S_ACC) && fin_r;
  assign fin_req.sum   = acc_sum;
  assign fin_req.cin   = cin_r;
  assign fin_req.scale = scale_r;

  mvma_finish u_finish (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fin_req),
    .res   (fin_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_mat) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: state_nxt = fin_r ? S_FIN : S_IDLE;
      S_FIN: begin
        if (fin_res.valid) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_cfg_r    <= 9'd1;
      cols_cfg_r    <= 9'd1;
      scale_r       <= 16'sd4096;
      transp_r      <= 1'b0;
      outer_r       <= '0;
      inner_r       <= '0;
      load_r        <= '0;
      running_sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_vec) begin
        load_r <= ((32'(load_r) + 32'd1) >= 32'(cols_eff)) ? '0 : load_r + CA'(1);
      end
      if (acc_mat) begin
        outer_r <= outer_nxt;
        inner_r <= inner_nxt;
      end
      if ((state_r == S_ACC) && !transp_r) begin
        running_sum_r <= fin_r ? '0 : acc_sum;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS:   rows_cfg_r <= cfg_data[8:0];
          REG_COLS:   cols_cfg_r <= cfg_data[8:0];
          REG_SCALE:  scale_r    <= $signed(cfg_data);
          REG_TRANSP: transp_r   <= cfg_data[0];
        endcase
        if (cfg_index != REG_SCALE) begin
          outer_r       <= '0;
          inner_r       <= '0;
          load_r        <= '0;
          running_sum_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_mat) begin
      a_r        <= in_value;
      cin_r      <= in_c_in;
      fin_r      <= transp_r ? outer_last : inner_last;
      first_r    <= (outer_r == '0);
      idx_r      <= transp_r ? 8'(inner_r) : 8'(outer_r);
      sum_addr_r <= inner_r[RA-1:0];
    end
    if (state_r == S_MUL) begin
      prod_r <= a_r * vec_rdata;
    end
  end

  assign out_strobe    = fin_res.valid;
  assign out_c_out     = fin_res.value;
  assign out_saturated = fin_res.sat;
  assign out_row_index = idx_r;

  `MVMA_ASSERT_IMP(a_strobe_in_fin, out_strobe, state_r == S_FIN, "result word outside finish phase")
  `MVMA_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result word repeated")
  `MVMA_ASSERT_NEXT(a_matrix_busy, acc_mat, busy, "matrix word did not start work")
  `MVMA_ASSERT_NEXT(a_vector_idle, acc_vec, !busy, "vector word made the core busy")

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the matrix-vector multiply-accumulate core
module testbench
  import mvma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_ROWS      = 256;
  localparam int          MAX_COLS      = 256;
  localparam logic        KIND_VEC      = 1'b0;
  localparam logic        KIND_MAT      = 1'b1;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          RANDOM_WORDS  = 200;
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  typedef struct {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
    logic signed [C_W-1:0]   c_in;
  } mac_word_t;

  typedef struct {
    logic signed [C_W-1:0] c_out;
    logic [7:0]            row;
    logic                  sat;
  } row_result_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  logic                    in_kind   = 1'b0;
  logic signed [VAL_W-1:0] in_value  = '0;
  logic signed [C_W-1:0]   in_c_in   = '0;
  logic                    out_strobe;
  logic signed [C_W-1:0]   out_c_out;
  logic [7:0]              out_row_index;
  logic                    out_saturated;
  logic                    cfg_we    = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [15:0]             cfg_data  = '0;

  // predictor state
  logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
  logic signed [SUM_W-1:0] col_acc [MAX_ROWS];
  logic signed [SUM_W-1:0] row_acc = '0;
  int unsigned             outer_pos = 0;
  int unsigned             inner_pos = 0;
  int unsigned             load_pos = 0;
  logic [8:0]              m_rows = 9'd1;
  logic [8:0]              m_cols = 9'd1;
  logic signed [15:0]      m_scale = 16'sd4096;
  logic                    m_transp = 1'b0;

  mac_word_t   word_queue[$];
  row_result_t expected_rows[$];
  int          mismatch_count = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned gen_np = 1;

  matrix_vector_multiply_accumulate_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .in_c_in      (in_c_in),
    .out_strobe   (out_strobe),
    .out_c_out    (out_c_out),
    .out_row_index(out_row_index),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_size(input logic [8:0] v, input int unsigned mx);
    if (v == 9'd0) return 1;
    return (32'(v) > mx) ? mx : 32'(v);
  endfunction

  function automatic row_result_t scale_and_clip(input logic signed [SUM_W-1:0] acc,
                                                 input logic signed [C_W-1:0] cin,
                                                 input int unsigned idx);
    row_result_t r;
    longint      prod;
    longint      tot;
    prod = longint'(m_scale) * longint'(acc);
    tot  = longint'(cin) + (prod >>> 26);
    r.sat = 1'b0;
    if (tot > 64'sh7FFF_FFFF) begin
      tot   = 64'sh7FFF_FFFF;
      r.sat = 1'b1;
    end else if (tot < -64'sh8000_0000) begin
      tot   = -64'sh8000_0000;
      r.sat = 1'b1;
    end
    r.c_out = tot[31:0];
    r.row   = idx[7:0];
    return r;
  endfunction

  function automatic bit gemv_step(input mac_word_t w, output row_result_t r);
    int unsigned             ni;
    int unsigned             np;
    logic signed [SUM_W-1:0] acc;
    bit                      done;
    ni   = eff_size(m_rows, MAX_ROWS);
    np   = eff_size(m_cols, MAX_COLS);
    done = 1'b0;
    r    = '{default: '0};
    if (w.kind == KIND_VEC) begin
      if (load_pos >= np) load_pos = 0;
      vec_mem[load_pos] = w.value;
      load_pos++;
      if (load_pos >= np) load_pos = 0;
    end else if (!m_transp) begin
      if (outer_pos >= ni) outer_pos = 0;
      if (inner_pos >= np) begin
        inner_pos = 0;
        row_acc   = '0;
      end
      row_acc = row_acc + w.value * vec_mem[inner_pos];
      inner_pos++;
      if (inner_pos >= np) begin
        r         = scale_and_clip(row_acc, w.c_in, outer_pos);
        done      = 1'b1;
        row_acc   = '0;
        inner_pos = 0;
        outer_pos++;
        if (outer_pos >= ni) outer_pos = 0;
      end
    end else begin
      if (outer_pos >= np) outer_pos = 0;
      if (inner_pos >= ni) inner_pos = 0;
      acc = (outer_pos == 0) ? '0 : col_acc[inner_pos];
      acc = acc + w.value * vec_mem[outer_pos];
      col_acc[inner_pos] = acc;
      if (outer_pos + 1 >= np) begin
        r    = scale_and_clip(acc, w.c_in, inner_pos);
        done = 1'b1;
      end
      inner_pos++;
      if (inner_pos >= ni) begin
        inner_pos = 0;
        outer_pos++;
        if (outer_pos >= np) outer_pos = 0;
      end
    end
    return done;
  endfunction

  always @(posedge clk) begin : driver
    mac_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        gap_left = $urandom_range(1, 18) - 1;
      end else if (word_queue.size() > 0) begin
        w = word_queue.pop_front();
        start    <= 1'b1;
        in_kind  <= w.kind;
        in_value <= w.value;
        in_c_in  <= w.c_in;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    mac_word_t   w;
    row_result_t r;
    row_result_t exp_r;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_rows.size() == 0) begin
          $error("result with no expectation: c_out %0d row %0d", out_c_out, out_row_index);
          mismatch_count++;
        end else begin
          exp_r = expected_rows.pop_front();
          if (out_c_out !== exp_r.c_out) begin
            $error("c_out: expected %0d, got %0d", exp_r.c_out, out_c_out);
            mismatch_count++;
          end
          if (out_row_index !== exp_r.row) begin
            $error("row_index: expected %0d, got %0d", exp_r.row, out_row_index);
            mismatch_count++;
          end
          if (out_saturated !== exp_r.sat) begin
            $error("saturated: expected %0d, got %0d", exp_r.sat, out_saturated);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        w.kind  = in_kind;
        w.value = in_value;
        w.c_in  = in_c_in;
        if (gemv_step(w, r)) expected_rows.push_back(r);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_cin();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
      1:       return 32'h8000_0000 + $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic kind, input logic [15:0] value,
                           input logic [31:0] cin);
    mac_word_t w;
    w.kind  = kind;
    w.value = value;
    w.c_in  = cin;
    word_queue.push_back(w);
  endtask

  task automatic push_vector(input int unsigned n);
    repeat (n) push_word(KIND_VEC, rand_value(), $urandom);
  endtask

  // mostly matrix words, with the odd vector reload mixed in
  task automatic push_matrix(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 24) == 0) push_word(KIND_VEC, rand_value(), $urandom);
      else push_word(KIND_MAT, rand_value(), rand_cin());
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS:   m_rows   = data[8:0];
      REG_COLS:   m_cols   = data[8:0];
      REG_SCALE:  m_scale  = data;
      REG_TRANSP: m_transp = data[0];
      default: ;
    endcase
    if (idx != REG_SCALE) begin
      outer_pos = 0;
      inner_pos = 0;
      load_pos  = 0;
      row_acc   = '0;
    end
  endtask

  task automatic configure(input logic [8:0] rows, input logic [8:0] cols,
                           input logic [15:0] scale_val, input logic transp);
    write_reg(REG_ROWS, {7'd0, rows});
    write_reg(REG_COLS, {7'd0, cols});
    write_reg(REG_SCALE, scale_val);
    write_reg(REG_TRANSP, {15'd0, transp});
    gen_np = eff_size(cols, MAX_COLS);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (word_queue.size() != 0 || start || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int          random_words;
    logic [8:0]  rows;
    logic [8:0]  cols;
    logic [15:0] scale_val;
    int unsigned n;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // default shape 1x1, unity scale: saturation both ways
    push_word(KIND_VEC, 16'h8000, 32'h0);
    push_word(KIND_MAT, 16'h8000, 32'h7FFF_FFFF);
    push_word(KIND_MAT, 16'h7FFF, 32'h8000_0000);
    push_word(KIND_MAT, 16'h0000, 32'h1234_5678);
    push_word(KIND_MAT, 16'h0001, 32'h0000_0000);
    drain();

    // zero sizes act as one, most negative scale
    configure(9'd0, 9'd0, 16'h8000, 1'b0);
    push_word(KIND_VEC, 16'h7FFF, 32'hFFFF_FFFF);
    push_word(KIND_MAT, 16'h7FFF, 32'h7FFF_FFFF);
    push_word(KIND_MAT, 16'h8000, 32'h8000_0000);
    push_word(KIND_MAT, 16'hFFFF, 32'hFFFF_FFFF);
    drain();

    // transposed 2x2, largest scale, then a vector reload that wraps
    configure(9'd2, 9'd2, 16'h7FFF, 1'b1);
    push_word(KIND_VEC, 16'h8000, 32'h0);
    push_word(KIND_VEC, 16'h7FFF, 32'h0);
    push_word(KIND_MAT, 16'h8000, 32'h7FFF_FFFF);
    push_word(KIND_MAT, 16'h7FFF, 32'h8000_0000);
    push_word(KIND_MAT, 16'h8000, 32'h7FFF_FFFF);
    push_word(KIND_MAT, 16'h7FFF, 32'h8000_0000);
    push_word(KIND_VEC, 16'h1234, 32'h0);
    push_word(KIND_VEC, 16'hEDCB, 32'h0);
    push_word(KIND_VEC, 16'h5555, 32'h0);
    push_word(KIND_MAT, 16'hAAAA, 32'h0000_0000);
    push_word(KIND_MAT, 16'h5555, 32'hFFFF_0000);
    drain();

    // oversize rows: the row count clamps to 256 outputs
    configure(9'd511, 9'd1, 16'($urandom), 1'b0);
    push_vector(gen_np);
    push_matrix(256);
    drain();

    // oversize columns in transposed order
    configure(9'd1, 9'd300, 16'($urandom), 1'b1);
    push_vector(gen_np);
    push_matrix(260);
    drain();

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      gaps_on = (random_words < RANDOM_WORDS - 60) && ($urandom_range(0, 3) != 0);
      scale_val = ($urandom_range(0, 4) == 0) ? rand_value() : 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_SCALE, scale_val);
      end else begin
        rows = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(7, 24))
                                           : 9'($urandom_range(0, 6));
        cols = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(7, 24))
                                           : 9'($urandom_range(0, 6));
        configure(rows, cols, scale_val, 1'($urandom));
        push_vector(gen_np);
        random_words += gen_np;
      end
      n = $urandom_range(10, 60);
      push_matrix(n);
      random_words += n;
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
